@@ src/mce_pkg.sv @@
`timescale 1ns / 1ps

package mce_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PAT_W       = 6;
  localparam int unsigned LEN_W       = 3;

  localparam logic [7:0] CHAR_ZERO     = 8'd48;
  localparam logic [7:0] CHAR_NINE     = 8'd57;
  localparam logic [7:0] CHAR_UPPER_A  = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z  = 8'd90;
  localparam logic [7:0] CHAR_COMMA    = 8'd44;
  localparam logic [7:0] CHAR_PERIOD   = 8'd46;
  localparam logic [7:0] CHAR_QUESTION = 8'd63;

  typedef enum logic [1:0] {
    KIND_DOT     = 2'd0,
    KIND_DASH    = 2'd1,
    KIND_GAP     = 2'd2,
    KIND_LITERAL = 2'd3
  } elem_kind_e;

  // One classified character. pat holds the elements left aligned, first
  // element in the top bit, dash = 1.
  typedef struct packed {
    logic             is_lit;
    logic [7:0]       lit;
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] pat;
  } mce_item_t;

  function automatic mce_item_t mk_pat(input logic [LEN_W-1:0] len,
                                       input logic [PAT_W-1:0] raw);
    mce_item_t it;
    it.is_lit = 1'b0;
    it.lit    = 8'd0;
    it.len    = len;
    it.pat    = raw << (LEN_W'(PAT_W) - len);
    return it;
  endfunction

  function automatic mce_item_t classify(input logic [7:0] c);
    mce_item_t it;
    it.is_lit = 1'b1;
    it.lit    = c;
    it.len    = '0;
    it.pat    = '0;
    case (c)
      8'd48: it = mk_pat(3'd5, 6'b011111);
      8'd49: it = mk_pat(3'd5, 6'b001111);
      8'd50: it = mk_pat(3'd5, 6'b000111);
      8'd51: it = mk_pat(3'd5, 6'b000011);
      8'd52: it = mk_pat(3'd5, 6'b000001);
      8'd53: it = mk_pat(3'd5, 6'b000000);
      8'd54: it = mk_pat(3'd5, 6'b010000);
      8'd55: it = mk_pat(3'd5, 6'b011000);
      8'd56: it = mk_pat(3'd5, 6'b011100);
      8'd57: it = mk_pat(3'd5, 6'b011110);
      8'd65: it = mk_pat(3'd2, 6'b000001);
      8'd66: it = mk_pat(3'd4, 6'b001000);
      8'd67: it = mk_pat(3'd4, 6'b001010);
      8'd68: it = mk_pat(3'd3, 6'b000100);
      8'd69: it = mk_pat(3'd1, 6'b000000);
      8'd70: it = mk_pat(3'd4, 6'b000010);
      8'd71: it = mk_pat(3'd3, 6'b000110);
      8'd72: it = mk_pat(3'd4, 6'b000000);
      8'd73: it = mk_pat(3'd2, 6'b000000);
      8'd74: it = mk_pat(3'd4, 6'b000111);
      8'd75: it = mk_pat(3'd3, 6'b000101);
      8'd76: it = mk_pat(3'd4, 6'b000100);
      8'd77: it = mk_pat(3'd2, 6'b000011);
      8'd78: it = mk_pat(3'd2, 6'b000010);
      8'd79: it = mk_pat(3'd3, 6'b000111);
      8'd80: it = mk_pat(3'd4, 6'b000110);
      8'd81: it = mk_pat(3'd4, 6'b001101);
      8'd82: it = mk_pat(3'd3, 6'b000010);
      8'd83: it = mk_pat(3'd3, 6'b000000);
      8'd84: it = mk_pat(3'd1, 6'b000001);
      8'd85: it = mk_pat(3'd3, 6'b000001);
      8'd86: it = mk_pat(3'd4, 6'b000001);
      8'd87: it = mk_pat(3'd3, 6'b000011);
      8'd88: it = mk_pat(3'd4, 6'b001001);
      8'd89: it = mk_pat(3'd4, 6'b001011);
      8'd90: it = mk_pat(3'd4, 6'b001100);
      8'd44: it = mk_pat(3'd6, 6'b110011);
      8'd46: it = mk_pat(3'd6, 6'b010101);
      8'd63: it = mk_pat(3'd6, 6'b001100);
      default: ;
    endcase
    return it;
  endfunction

endpackage

@@ src/morse_code_encoder.sv @@
`timescale 1ns / 1ps
// An accepted character passes through the queue and the back end's current-item register
// before its first result strobes. Throughput: one result per cycle while characters are
// queued; a character gives its elements and a closing gap, 2 to 7 results, and a
// pass-through byte gives one, set by the one-element-per-cycle output serializer. busy
// rises only when the character queue (QueueDepth entries) is full; the receiver cannot
// stall results. Reset (rst_ni low, asynchronous) empties the queue and drops any run in progress.

module morse_code_encoder
  import mce_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] char_code_i,
  output logic       strobe_o,
  output logic [1:0] element_kind_o,
  output logic [7:0] literal_byte_o,
  output logic       last_of_run_o
);

  mce_item_t front_item, head_item;
  logic      push, pop, q_empty, q_full;

  // Front end: accept a character and look up its Morse pattern in one step.
  mce_front u_front (
    .start_i     (start),
    .full_i      (q_full),
    .char_code_i (char_code_i),
    .push_o      (push),
    .item_o      (front_item)
  );

  // Short queue decouples accepting characters from serializing elements.
  mce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Back end: advance one element per cycle, close with a gap or pass a literal, flag the last.
  mce_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (head_item),
    .empty_i        (q_empty),
    .pop_o          (pop),
    .strobe_o       (strobe_o),
    .element_kind_o (element_kind_o),
    .literal_byte_o (literal_byte_o),
    .last_of_run_o  (last_of_run_o)
  );

  assign busy = q_full;

endmodule

@@ src/mce_front.sv @@
`timescale 1ns / 1ps

module mce_front
  import mce_pkg::*;
(
  input  logic       start_i,
  input  logic       full_i,
  input  logic [7:0] char_code_i,
  output logic       push_o,
  output mce_item_t  item_o
);

  // Take the character when the queue has room; look up its pattern.
  assign push_o = start_i & ~full_i;
  assign item_o = classify(char_code_i);

endmodule

@@ src/mce_queue.sv @@
`timescale 1ns / 1ps

module mce_queue
  import mce_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mce_item_t item_i,
  input  logic      pop_i,
  output mce_item_t item_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mce_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ src/mce_back.sv @@
`timescale 1ns / 1ps

module mce_back
  import mce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mce_item_t  item_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       strobe_o,
  output logic [1:0] element_kind_o,
  output logic [7:0] literal_byte_o,
  output logic       last_of_run_o
);

  logic             active_q, active_d;
  mce_item_t        cur_q, cur_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             done;
  logic             strobe_q;
  elem_kind_e       kind_q, kind_d;
  logic [7:0]       lit_q, lit_d;
  logic             last_q, last_d;

  // Finish the item this cycle on a literal or on the closing gap.
  assign done  = active_q & (cur_q.is_lit | (rem_q == '0));
  assign pop_o = (~active_q | done) & ~empty_i;

  always_comb begin
    kind_d   = KIND_GAP;
    lit_d    = 8'd0;
    last_d   = 1'b0;
    cur_d    = cur_q;
    rem_d    = rem_q;
    active_d = active_q;
    if (active_q) begin
      if (cur_q.is_lit) begin
        kind_d = KIND_LITERAL;
        lit_d  = cur_q.lit;
        last_d = 1'b1;
      end else if (rem_q != '0) begin
        kind_d    = cur_q.pat[PAT_W-1] ? KIND_DASH : KIND_DOT;
        cur_d.pat = cur_q.pat << 1;
        rem_d     = rem_q - 1'b1;
      end else begin
        kind_d = KIND_GAP;
        last_d = 1'b1;
      end
    end
    if (pop_o) begin
      cur_d    = item_i;
      rem_d    = item_i.len;
      active_d = 1'b1;
    end else if (done) begin
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      active_q <= active_d;
      strobe_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    rem_q  <= rem_d;
    kind_q <= kind_d;
    lit_q  <= lit_d;
    last_q <= last_d;
  end

  assign strobe_o       = strobe_q;
  assign element_kind_o = kind_q;
  assign literal_byte_o = lit_q;
  assign last_of_run_o  = last_q;

endmodule

@@ test/morse_code_encoder_test.sv @@
`timescale 1ns / 1ps

// Drive character items into the encoder and check every element it emits.
// A local predictor turns each accepted item into the list of elements it
// should produce. A checker on the result strobe compares each element, in
// order, against that list.

module morse_code_encoder_test;
  import mce_pkg::*;

  localparam int ClkPeriod = 20;

  // One element the encoder should emit.
  typedef struct {
    elem_kind_e kind;
    logic [7:0] lit;
    logic       last;
  } morse_elem_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [7:0] char_code_i;
  logic       strobe_o;
  logic [1:0] element_kind_o;
  logic [7:0] literal_byte_o;
  logic       last_of_run_o;

  // Elements predicted for accepted items, oldest first.
  morse_elem_t pending_elems[$];

  int unsigned mismatch_cnt;
  int unsigned burst_left;
  int unsigned drain_cycles;
  bit          gaps_on;

  // Dot/dash spelling of each mapped character.
  string digit_pats[10] = '{
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };
  string letter_pats[26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };

  morse_code_encoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .char_code_i    (char_code_i),
    .strobe_o       (strobe_o),
    .element_kind_o (element_kind_o),
    .literal_byte_o (literal_byte_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Return the dot/dash spelling of a byte, or an empty string when the byte
  // has no Morse pattern and passes through literally.
  function automatic string morse_pattern(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return digit_pats[c - CHAR_ZERO];
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return letter_pats[c - CHAR_UPPER_A];
    if (c == CHAR_COMMA) return "--..--";
    if (c == CHAR_PERIOD) return ".-.-.-";
    if (c == CHAR_QUESTION) return "..--..";
    return "";
  endfunction

  // Queue up the elements one accepted character should produce.
  function automatic void predict_morse(input logic [7:0] c);
    string       pat;
    morse_elem_t el;
    pat = morse_pattern(c);
    if (pat.len() == 0) begin
      // Unmapped byte: one literal result, flagged as last.
      el.kind = KIND_LITERAL;
      el.lit  = c;
      el.last = 1'b1;
      pending_elems.push_back(el);
      return;
    end
    el.lit  = 8'd0;
    el.last = 1'b0;
    for (int i = 0; i < pat.len(); i++) begin
      el.kind = (pat[i] == "-") ? KIND_DASH : KIND_DOT;
      pending_elems.push_back(el);
    end
    // Close the run with a character gap.
    el.kind = KIND_GAP;
    el.last = 1'b1;
    pending_elems.push_back(el);
  endfunction

  // Send one item. Call at a falling edge; return at a falling edge.
  // Between bursts, when gaps are on, drop start for a random gap, possibly none, and put
  // noise on the data port while it is low.
  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        start       <= 1'b0;
        char_code_i <= 8'($urandom);
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    start       <= 1'b1;
    char_code_i <= c;
    // Hold the item until an edge sees busy low.
    do @(posedge clk_i); while (busy);
    predict_morse(c);
    @(negedge clk_i);
  endtask

  // Pick a byte, weighted toward mapped characters so long runs dominate.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'(CHAR_UPPER_A + $urandom_range(0, 25));
      4:          return 8'(CHAR_ZERO + $urandom_range(0, 9));
      5: begin
        case ($urandom_range(0, 2))
          0:       return CHAR_COMMA;
          1:       return CHAR_PERIOD;
          default: return CHAR_QUESTION;
        endcase
      end
      6:       return 8'($urandom_range(97, 122));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Field extremes and every bit of the input in both states.
  task automatic test_extremes();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h80);
    send_char(8'h7F);
    send_char(8'h55);
    send_char(8'hAA);
  endtask

  // Digits: both ends of the range and the all-dot one.
  task automatic test_digits();
    send_char("0");
    send_char("5");
    send_char("9");
  endtask

  // Letters: both ends, the one- and four-element cases, and H, which must
  // end in a gap like any other letter.
  task automatic test_letters();
    send_char("A");
    send_char("E");
    send_char("H");
    send_char("T");
    send_char("Q");
    send_char("Z");
  endtask

  // The three six-element punctuation marks: the longest runs.
  task automatic test_punctuation();
    send_char(",");
    send_char(".");
    send_char("?");
  endtask

  // Lowercase, space and bytes just outside each mapped range all pass through.
  task automatic test_unmapped();
    send_char("a");
    send_char("z");
    send_char(" ");
    send_char("/");
    send_char(":");
    send_char("@");
    send_char("[");
  endtask

  // Random characters with random bursts and gaps.
  task automatic test_random(input int unsigned count);
    repeat (count) send_char(pick_char());
  endtask

  // Back-to-back long runs: fill the character queue so busy has to rise.
  task automatic test_back_to_back(input int unsigned count);
    gaps_on = 1'b0;
    repeat (count) send_char(($urandom_range(0, 1) != 0) ? pick_char() : CHAR_COMMA);
    gaps_on = 1'b1;
  endtask

  // Compare each strobed result against the oldest pending element.
  always @(posedge clk_i) begin
    morse_elem_t want;
    if (rst_ni && strobe_o) begin
      if (pending_elems.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: kind %0d byte %h last %b",
                   element_kind_o, literal_byte_o, last_of_run_o);
      end else begin
        want = pending_elems.pop_front();
        if (element_kind_o !== want.kind || literal_byte_o !== want.lit ||
            last_of_run_o !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected kind %0d byte %h last %b, got kind %0d byte %h last %b",
                     want.kind, want.lit, want.last,
                     element_kind_o, literal_byte_o, last_of_run_o);
        end
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    char_code_i  = 8'd0;
    gaps_on      = 1'b1;
    burst_left   = 0;
    mismatch_cnt = 0;
    drain_cycles = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_digits();
    test_letters();
    test_punctuation();
    test_unmapped();
    test_random(165);
    test_back_to_back(40);

    start <= 1'b0;
    // Drain: wait, up to a bound, for the last runs to come out, then idle so stray results show.
    while (pending_elems.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (10) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_elems.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(2_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
